### rtl/hsa_pkg.sv
// Shared types and operation codes for the handle slot allocator.
package hsa_pkg;

  // Operation codes carried on the request channel.
  typedef enum logic [1:0] {
    OP_ALLOCATE = 2'd0,
    OP_ASSIGN   = 2'd1,
    OP_CLOSE    = 2'd2,
    OP_LOOKUP   = 2'd3
  } op_t;

  // Sequencer states, one-hot coded.
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_CHECK = 6'b001000,
    S_DOWN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

endpackage

### rtl/handle_slot_allocator_core.sv
// Handle slot allocator: a slot table of object references with a scan sequencer.
//
// The slot table is one synchronous memory of HANDLE_COUNT 32-bit entries, and a
// zero entry is an empty slot. After reset the block runs a clearing pass that
// writes zero to every slot, during which in_stall stays high. Each request then
// goes through the one memory read port. Lookup, assign, and a close that leaves
// the high-water mark alone form the result from their slot read in S_CHECK, then
// move it to the output register in S_EMIT. Allocate scans one slot per cycle
// from its start slot until it finds an empty slot or reaches the table end. A
// close of the topmost public slot walks down one slot per cycle past trailing
// empty slots. A refused request goes from acceptance straight to S_EMIT. A new
// request is taken once the previous result sits in the output register, even if
// that result has not been taken yet.
module handle_slot_allocator_core
  import hsa_pkg::*;
#(
  parameter int HANDLE_COUNT     = 1024,
  parameter int RESERVED_HANDLES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [9:0]  in_handle,
  input  logic [31:0] in_object_ref,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [9:0]  out_given_handle,
  output logic [31:0] out_found_ref
);

  localparam int CW = $clog2(HANDLE_COUNT + 1);
  localparam int IW = $clog2(HANDLE_COUNT);
  localparam bit NO_PUBLIC = (RESERVED_HANDLES >= HANDLE_COUNT);
  localparam logic [CW-1:0] HC_C  = CW'(HANDLE_COUNT);
  localparam logic [CW-1:0] RES_C = NO_PUBLIC ? CW'(0) : CW'(RESERVED_HANDLES);

  // Slot memory with a registered read port.
  logic [31:0]   mem [HANDLE_COUNT];
  logic [31:0]   mem_q_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [IW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[rd_addr];
  end

  // Control and working registers.
  state_t        state_r, state_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] mark_r, mark_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  op_t           op_r, op_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [31:0]   obj_r, obj_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic [9:0]    res_handle_r, res_handle_nxt;
  logic [31:0]   res_ref_r, res_ref_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic [9:0]    out_handle_r, out_handle_nxt;
  logic [31:0]   out_ref_r, out_ref_nxt;

  // Helper values.
  logic [31:0]   handle_ext;
  logic          in_range;
  logic          is_reserved;
  logic          use_mark;
  logic [CW-1:0] alloc_start;
  logic [CW-1:0] scan_next;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] top_dec;
  logic [31:0]   scan_ext;
  logic          accept;
  logic          out_free;

  assign handle_ext  = 32'(in_handle);
  assign in_range    = (handle_ext < 32'(HANDLE_COUNT));
  assign is_reserved = (handle_ext < 32'(RESERVED_HANDLES));
  assign use_mark    = ({used_r, 2'b00} > ({1'b0, mark_r, 1'b0} + {2'b00, mark_r}))
                       && (mark_r > RES_C);
  assign alloc_start = use_mark ? mark_r : RES_C;
  assign scan_next   = scan_r + CW'(1);
  assign idx_ext     = CW'(idx_r);
  assign top_dec     = scan_r - CW'(1);
  assign scan_ext    = 32'(scan_r);
  assign accept      = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_given_handle = out_handle_r;
  assign out_found_ref    = out_ref_r;

  // Sequencer: clearing pass, request decode, slot scans and result hand-off.
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    mark_nxt       = mark_r;
    scan_nxt       = scan_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    obj_nxt        = obj_r;
    res_ok_nxt     = res_ok_r;
    res_handle_nxt = res_handle_r;
    res_ref_nxt    = res_ref_r;
    out_ok_nxt     = out_ok_r;
    out_handle_nxt = out_handle_r;
    out_ref_nxt    = out_ref_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = 32'd0;
    rd_addr        = handle_ext[IW-1:0];

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan_r[IW-1:0];
        scan_nxt  = scan_next;
        if (scan_next == HC_C) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_operation == OP_ALLOCATE) begin
          rd_addr = alloc_start[IW-1:0];
        end
        if (accept) begin
          op_nxt         = op_t'(in_operation);
          idx_nxt        = handle_ext[IW-1:0];
          obj_nxt        = in_object_ref;
          res_ok_nxt     = 1'b0;
          res_handle_nxt = 10'd0;
          res_ref_nxt    = 32'd0;
          state_nxt      = S_EMIT;
          case (op_t'(in_operation))
            OP_ALLOCATE: begin
              // A null object, a table with no public slots, or a start at the table end fails at once.
              if (in_object_ref != 32'd0 && !NO_PUBLIC && alloc_start != HC_C) begin
                scan_nxt  = alloc_start;
                state_nxt = S_SCAN;
              end
            end
            OP_ASSIGN: begin
              if (in_range && is_reserved && in_object_ref != 32'd0) begin
                state_nxt = S_CHECK;
              end
            end
            default: begin
              if (in_range) begin
                state_nxt = S_CHECK;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read data for slot scan_r arrives now; the next slot is read meanwhile.
        rd_addr = scan_next[IW-1:0];
        if (mem_q_r == 32'd0) begin
          mem_we         = 1'b1;
          mem_waddr      = scan_r[IW-1:0];
          mem_wdata      = obj_r;
          used_nxt       = used_r + CW'(1);
          if (scan_next > mark_r) begin
            mark_nxt = scan_next;
          end
          res_ok_nxt     = 1'b1;
          res_handle_nxt = scan_ext[9:0];
          state_nxt      = S_EMIT;
        end else if (scan_next == HC_C) begin
          state_nxt = S_EMIT;
        end else begin
          scan_nxt = scan_next;
        end
      end

      S_CHECK: begin
        rd_addr   = idx_r - IW'(1);
        state_nxt = S_EMIT;
        case (op_r)
          OP_ASSIGN: begin
            mem_we      = 1'b1;
            mem_wdata   = obj_r;
            if (mem_q_r == 32'd0) begin
              used_nxt = used_r + CW'(1);
            end
            res_ok_nxt  = 1'b1;
            res_ref_nxt = mem_q_r;
          end
          OP_CLOSE: begin
            if (mem_q_r != 32'd0) begin
              mem_we      = 1'b1;
              mem_wdata   = 32'd0;
              if (used_r != CW'(0)) begin
                used_nxt = used_r - CW'(1);
              end
              res_ok_nxt  = 1'b1;
              res_ref_nxt = mem_q_r;
              // Closing the topmost public slot lowers the mark.
              if (!NO_PUBLIC && idx_ext >= RES_C && (idx_ext + CW'(1)) >= mark_r) begin
                if (idx_ext > RES_C) begin
                  scan_nxt  = idx_ext;
                  state_nxt = S_DOWN;
                end else begin
                  mark_nxt = idx_ext;
                end
              end
            end
          end
          default: begin
            res_ok_nxt  = 1'b1;
            res_ref_nxt = mem_q_r;
          end
        endcase
      end

      S_DOWN: begin
        // Read data for slot scan_r - 1 arrives now.
        rd_addr = IW'(top_dec - CW'(1));
        if (mem_q_r == 32'd0) begin
          scan_nxt = top_dec;
          if (top_dec == RES_C) begin
            mark_nxt  = top_dec;
            state_nxt = S_EMIT;
          end
        end else begin
          mark_nxt  = scan_r;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = res_ok_r;
          out_handle_nxt = res_handle_r;
          out_ref_nxt    = res_ref_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      used_r      <= '0;
      mark_r      <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      mark_r      <= mark_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    obj_r        <= obj_nxt;
    res_ok_r     <= res_ok_nxt;
    res_handle_r <= res_handle_nxt;
    res_ref_r    <= res_ref_nxt;
    out_ok_r     <= out_ok_nxt;
    out_handle_r <= out_handle_nxt;
    out_ref_r    <= out_ref_nxt;
  end

endmodule

### tb/tb_handle_slot_allocator_core.sv
// Self-checking testbench for the handle slot allocator core.
module tb_handle_slot_allocator_core;
  import hsa_pkg::*;

  localparam int HANDLE_COUNT     = 1024;
  localparam int RESERVED_HANDLES = 16;
  localparam int STALL_LIMIT      = 8000;
  localparam int DRAIN_CYCLES     = 50;
  localparam int DIRECTED_ROWS    = 23;
  localparam int REPORT_LIMIT     = 10;

  typedef struct packed {
    logic        ok;
    logic [9:0]  given_handle;
    logic [31:0] found_ref;
  } reply_t;

  typedef struct packed {
    op_t         operation;
    logic [9:0]  handle;
    logic [31:0] object_ref;
    logic        typed;
    reply_t      reply;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [9:0]  in_handle;
  logic [31:0] in_object_ref;
  logic        out_valid;
  logic        out_stall;
  logic        out_ok;
  logic [9:0]  out_given_handle;
  logic [31:0] out_found_ref;

  // Mirror of the slot table and its bookkeeping.
  logic [31:0] slot_mirror [HANDLE_COUNT];
  int unsigned live_count;
  int unsigned mark_mirror;
  int          refused_allocs;

  reply_t      replies_due [$];
  step_row_t   directed_rows [DIRECTED_ROWS];
  int          mismatches;
  int          idle_cycles;
  int          send_gap_pct;
  int          recv_stall_pct;

  handle_slot_allocator_core #(
    .HANDLE_COUNT     (HANDLE_COUNT),
    .RESERVED_HANDLES (RESERVED_HANDLES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_handle        (in_handle),
    .in_object_ref    (in_object_ref),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_given_handle (out_given_handle),
    .out_found_ref    (out_found_ref)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the mirrored table and return the reply it should produce.
  function automatic reply_t table_apply(op_t op, logic [9:0] handle, logic [31:0] obj);
    reply_t      rep;
    int unsigned idx;
    int unsigned top;
    rep = '0;
    idx = 32'(handle);
    case (op)
      OP_ALLOCATE: begin
        if (obj != 32'd0) begin
          // A dense table starts the scan at the high-water mark.
          idx = RESERVED_HANDLES;
          if (live_count * 4 > mark_mirror * 3 && mark_mirror > idx) idx = mark_mirror;
          while (idx < HANDLE_COUNT && slot_mirror[10'(idx)] != 32'd0) idx++;
          if (idx < HANDLE_COUNT) begin
            slot_mirror[10'(idx)] = obj;
            live_count++;
            if (idx + 1 > mark_mirror) mark_mirror = idx + 1;
            rep.ok = 1'b1;
            rep.given_handle = idx[9:0];
          end else begin
            refused_allocs++;
          end
        end
      end
      OP_ASSIGN: begin
        if (idx < RESERVED_HANDLES && obj != 32'd0) begin
          rep.ok = 1'b1;
          rep.found_ref = slot_mirror[10'(idx)];
          if (slot_mirror[10'(idx)] == 32'd0) live_count++;
          slot_mirror[10'(idx)] = obj;
        end
      end
      OP_CLOSE: begin
        if (slot_mirror[10'(idx)] != 32'd0) begin
          rep.ok = 1'b1;
          rep.found_ref = slot_mirror[10'(idx)];
          slot_mirror[10'(idx)] = 32'd0;
          if (live_count > 0) live_count--;
          // Closing the top public slot walks the mark down past empty slots.
          if (idx >= RESERVED_HANDLES && idx + 1 >= mark_mirror) begin
            top = idx;
            while (top > RESERVED_HANDLES && slot_mirror[10'(top - 1)] == 32'd0) top--;
            mark_mirror = top;
          end
        end
      end
      default: begin
        rep.ok = 1'b1;
        rep.found_ref = slot_mirror[10'(idx)];
      end
    endcase
    return rep;
  endfunction

  // Object reference with a chance of null and of all ones.
  function automatic logic [31:0] random_ref(int null_pct);
    int          pick;
    logic [31:0] r;
    pick = $urandom_range(99);
    if (pick < null_pct) return 32'd0;
    if (pick < null_pct + 3) return 32'hFFFF_FFFF;
    r = $urandom;
    if (r == 32'd0) r = 32'd1;
    return r;
  endfunction

  // Present one request, hold it until taken, and record its reply.
  task automatic send_request(input op_t op, input logic [9:0] handle,
                              input logic [31:0] obj, input logic typed,
                              input reply_t typed_reply);
    reply_t rep;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_handle     <= handle;
    in_object_ref <= obj;
    do @(posedge clk); while (in_stall);
    rep = table_apply(op, handle, obj);
    if (typed) rep = typed_reply;
    replies_due.push_back(rep);
    @(negedge clk);
  endtask

  // Random request with the given operation mix; handles mostly near the live region.
  task automatic send_mixed(input int alloc_pct, input int assign_pct, input int close_pct);
    int          pick;
    int unsigned span;
    op_t         op;
    logic [9:0]  handle;
    pick = $urandom_range(99);
    if (pick < alloc_pct) op = OP_ALLOCATE;
    else if (pick < alloc_pct + assign_pct) op = OP_ASSIGN;
    else if (pick < alloc_pct + assign_pct + close_pct) op = OP_CLOSE;
    else op = OP_LOOKUP;
    span = (mark_mirror > RESERVED_HANDLES ? mark_mirror : RESERVED_HANDLES) + 1;
    if (span > HANDLE_COUNT - 1) span = HANDLE_COUNT - 1;
    if ($urandom_range(9) == 0) handle = 10'($urandom_range(HANDLE_COUNT - 1));
    else if (op == OP_ASSIGN) handle = 10'($urandom_range(RESERVED_HANDLES - 1));
    else handle = 10'($urandom_range(span));
    send_request(op, handle, random_ref(8), 1'b0, '0);
  endtask

  // The sender idles until every expected reply has come back.
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  task automatic note_mismatch(input reply_t want, input logic unexpected);
    if (mismatches < REPORT_LIMIT) begin
      if (unexpected)
        $display("unexpected reply: ok=%0d handle=%0d ref=%h",
                 out_ok, out_given_handle, out_found_ref);
      else
        $display("reply mismatch: expected ok=%0d handle=%0d ref=%h, got ok=%0d handle=%0d ref=%h",
                 want.ok, want.given_handle, want.found_ref,
                 out_ok, out_given_handle, out_found_ref);
    end
    mismatches++;
  endtask

  // The receiver stalls at random on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check each taken reply against the oldest expectation, and watch for a hang.
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        note_mismatch('0, 1'b1);
      end else begin
        want = replies_due.pop_front();
        if (out_ok !== want.ok || out_given_handle !== want.given_handle ||
            out_found_ref !== want.found_ref)
          note_mismatch(want, 1'b0);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int start_refused;
    int sent;
    in_valid       = 1'b0;
    in_operation   = OP_ALLOCATE;
    in_handle      = '0;
    in_object_ref  = '0;
    out_stall      = 1'b0;
    rst_n          = 1'b0;
    mismatches     = 0;
    idle_cycles    = 0;
    refused_allocs = 0;
    live_count     = 0;
    mark_mirror    = 0;
    send_gap_pct   = 16;
    recv_stall_pct = 50;
    slot_mirror    = '{default: 32'd0};

    // Directed requests; rows with typed replies are checked against those values.
    directed_rows = '{
      '{OP_LOOKUP,   10'd0,    32'h0000_0000, 1'b1, '{1'b1, 10'd0,  32'h0000_0000}},
      '{OP_LOOKUP,   10'd1023, 32'h0000_0000, 1'b1, '{1'b1, 10'd0,  32'h0000_0000}},
      '{OP_ALLOCATE, 10'd0,    32'h0000_0000, 1'b1, '{1'b0, 10'd0,  32'h0000_0000}},
      '{OP_ALLOCATE, 10'd1023, 32'hFFFF_FFFF, 1'b1, '{1'b1, 10'd16, 32'h0000_0000}},
      '{OP_ALLOCATE, 10'd0,    32'h0000_0001, 1'b1, '{1'b1, 10'd17, 32'h0000_0000}},
      '{OP_ASSIGN,   10'd0,    32'hA5A5_A5A5, 1'b1, '{1'b1, 10'd0,  32'h0000_0000}},
      '{OP_ASSIGN,   10'd15,   32'hFFFF_FFFF, 1'b1, '{1'b1, 10'd0,  32'h0000_0000}},
      '{OP_ASSIGN,   10'd15,   32'h1234_5678, 1'b1, '{1'b1, 10'd0,  32'hFFFF_FFFF}},
      '{OP_ASSIGN,   10'd16,   32'h0000_0005, 1'b1, '{1'b0, 10'd0,  32'h0000_0000}},
      '{OP_ASSIGN,   10'd3,    32'h0000_0000, 1'b1, '{1'b0, 10'd0,  32'h0000_0000}},
      '{OP_ASSIGN,   10'd1023, 32'h0000_0007, 1'b1, '{1'b0, 10'd0,  32'h0000_0000}},
      '{OP_CLOSE,    10'd0,    32'h0000_0000, 1'b1, '{1'b1, 10'd0,  32'hA5A5_A5A5}},
      '{OP_CLOSE,    10'd0,    32'hFFFF_FFFF, 1'b1, '{1'b0, 10'd0,  32'h0000_0000}},
      '{OP_CLOSE,    10'd1023, 32'h0000_0000, 1'b1, '{1'b0, 10'd0,  32'h0000_0000}},
      '{OP_LOOKUP,   10'd15,   32'h0000_0000, 1'b1, '{1'b1, 10'd0,  32'h1234_5678}},
      '{OP_LOOKUP,   10'd16,   32'h0000_0000, 1'b1, '{1'b1, 10'd0,  32'hFFFF_FFFF}},
      '{OP_CLOSE,    10'd17,   32'h0000_0000, 1'b1, '{1'b1, 10'd0,  32'h0000_0001}},
      '{OP_ASSIGN,   10'd1,    32'h0000_0001, 1'b0, '0},
      '{OP_ASSIGN,   10'd2,    32'h8000_0000, 1'b0, '0},
      '{OP_ALLOCATE, 10'd0,    32'h0F0F_0F0F, 1'b0, '0},
      '{OP_CLOSE,    10'd16,   32'h0000_0000, 1'b0, '0},
      '{OP_ALLOCATE, 10'd512,  32'h0000_0002, 1'b0, '0},
      '{OP_CLOSE,    10'd15,   32'h0000_0000, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_request(directed_rows[i].operation, directed_rows[i].handle,
                   directed_rows[i].object_ref, directed_rows[i].typed,
                   directed_rows[i].reply);

    // Mixed traffic with a busy sender and an often stalling receiver.
    repeat (75) send_mixed(35, 15, 25);

    // The sender holds off until every reply is back.
    wait_for_replies();

    // Mixed traffic with a sparse sender and a mostly ready receiver.
    send_gap_pct   = 50;
    recv_stall_pct = 16;
    repeat (75) send_mixed(35, 15, 25);
    wait_for_replies();

    // No idling: fill the table until allocation has run out of slots six times, or 1300 requests are sent.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    start_refused  = refused_allocs;
    sent           = 0;
    while (refused_allocs < start_refused + 6 && sent < 1300) begin
      if ($urandom_range(99) < 88)
        send_request(OP_ALLOCATE, 10'($urandom_range(HANDLE_COUNT - 1)), random_ref(2),
                     1'b0, '0);
      else
        send_mixed(0, 50, 0);
      sent++;
    end

    // Punch holes into the full table and try to reuse them.
    repeat (80) send_mixed(30, 10, 40);

    wait_for_replies();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
